/* rtl/i2cm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the I2C master bit engine.
// No dependencies; imported by every module of the block.
package i2cm_pkg;

  localparam logic [2:0] ACT_ADDR_WR   = 3'd0;
  localparam logic [2:0] ACT_ADDR_RD   = 3'd1;
  localparam logic [2:0] ACT_SEND      = 3'd2;
  localparam logic [2:0] ACT_READ_ACK  = 3'd3;
  localparam logic [2:0] ACT_READ_NACK = 3'd4;
  localparam logic [2:0] ACT_STOP      = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ADDR_NACK = 2'd1;
  localparam logic [1:0] ST_DATA_NACK = 2'd2;

  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_ADDR,
    KIND_SEND,
    KIND_READ,
    KIND_STOP
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_START_SDA,
    PH_START_SCL,
    PH_TX_DRIVE,
    PH_TX_HIGH,
    PH_TX_LOW,
    PH_ACK_REL,
    PH_ACK_HIGH,
    PH_ACK_POLL,
    PH_RX_HIGH,
    PH_RX_LOW,
    PH_MACK_LOW,
    PH_MACK_HIGH,
    PH_MACK_END,
    PH_STOP_B,
    PH_FAIL_STOP
  } phase_t;

  typedef struct packed {
    logic       sda_in;
    kind_t      kind;
    logic [2:0] act;
    logic [7:0] load;
    logic [7:0] retries;
    logic       stop_flag;
  } q_item_t;

endpackage

/* rtl/i2cm_front.sv */
`timescale 1ns / 1ps
// Front end: takes input beats and classifies the offered command.
// Depends on i2cm_pkg; feeds i2cm_queue.
module i2cm_front
  import i2cm_pkg::*;
(
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_sda_in,
  input  logic       in_cmd_valid,
  input  logic [2:0] in_action,
  input  logic [6:0] in_target_address,
  input  logic [7:0] in_data_byte,
  input  logic [7:0] in_retries,
  input  logic       in_stop_after,
  input  logic       q_full,
  output logic       q_push,
  output q_item_t    q_item
);

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item           = '0;
    q_item.sda_in    = in_sda_in;
    q_item.act       = in_action;
    q_item.retries   = in_retries;
    q_item.kind      = KIND_NONE;
    if (in_cmd_valid) begin
      case (in_action)
        ACT_ADDR_WR, ACT_ADDR_RD: begin
          q_item.kind = KIND_ADDR;
          q_item.load = {in_target_address, in_action[0]};
        end
        ACT_SEND: begin
          q_item.kind      = KIND_SEND;
          q_item.load      = in_data_byte;
          q_item.stop_flag = in_stop_after;
        end
        ACT_READ_ACK, ACT_READ_NACK: begin
          q_item.kind      = KIND_READ;
          q_item.stop_flag = (in_action == ACT_READ_NACK);
        end
        ACT_STOP: begin
          q_item.kind = KIND_STOP;
        end
        default: begin
          q_item.kind = KIND_NONE;
        end
      endcase
    end
  end

endmodule

/* rtl/i2cm_queue.sv */
`timescale 1ns / 1ps
// Short FIFO of classified beats between the front end and the engine.
// Depends on i2cm_pkg for the entry type.
module i2cm_queue
  import i2cm_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output q_item_t head_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_item_t         mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count exceeds depth");

endmodule

/* rtl/i2cm_engine.sv */
`timescale 1ns / 1ps
// Back end: bus sequencer that advances one step per beat, plus the
// result register and the ack timeout register. Depends on i2cm_pkg.
module i2cm_engine
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       q_valid,
  input  q_item_t    q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_scl_level,
  output logic       out_sda_level,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [1:0] out_status,
  output logic [7:0] out_read_data
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  bit_cnt_r, bit_cnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  retries_r, retries_nxt;
  logic [7:0]  ack_wait_r, ack_wait_nxt;
  logic [2:0]  act_r, act_nxt;
  logic        stop_pend_r, stop_pend_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic [7:0]  ack_timeout_r;

  logic        out_valid_r;
  logic        out_scl_r, out_sda_r, out_busy_r, out_done_r;
  logic [1:0]  out_status_r;
  logic [7:0]  out_rd_r;

  logic        step;
  logic        done;
  logic [1:0]  status;
  logic [7:0]  rd;
  logic [3:0]  bit_inc;
  logic        byte_end;
  logic        ack_expired;
  logic        is_addr;
  logic        is_read;

  assign step        = q_valid && (!out_valid_r || out_ready);
  assign q_pop       = step;
  assign bit_inc     = bit_cnt_r + 4'd1;
  assign byte_end    = (bit_inc >= 4'd8);
  assign ack_expired = (ack_wait_r >= ack_timeout_r);
  assign is_addr     = (act_r == ACT_ADDR_WR) || (act_r == ACT_ADDR_RD);
  assign is_read     = (act_r == ACT_READ_ACK) || (act_r == ACT_READ_NACK);

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_IDLE: begin
        case (q_item.kind)
          KIND_ADDR: phase_nxt = PH_START_SDA;
          KIND_SEND: phase_nxt = PH_TX_HIGH;
          KIND_READ: phase_nxt = PH_RX_HIGH;
          KIND_STOP: phase_nxt = PH_STOP_B;
          default:   phase_nxt = PH_IDLE;
        endcase
      end
      PH_START_SDA: phase_nxt = PH_START_SCL;
      PH_START_SCL: phase_nxt = PH_TX_DRIVE;
      PH_TX_DRIVE:  phase_nxt = PH_TX_HIGH;
      PH_TX_HIGH:   phase_nxt = PH_TX_LOW;
      PH_TX_LOW:    phase_nxt = byte_end ? PH_ACK_REL : PH_TX_DRIVE;
      PH_ACK_REL:   phase_nxt = PH_ACK_HIGH;
      PH_ACK_HIGH:  phase_nxt = PH_ACK_POLL;
      PH_ACK_POLL: begin
        if (!q_item.sda_in) begin
          phase_nxt = (act_r == ACT_SEND && stop_pend_r) ? PH_STOP_B : PH_IDLE;
        end else if (ack_expired) begin
          phase_nxt = PH_FAIL_STOP;
        end
      end
      PH_RX_HIGH:   phase_nxt = byte_end ? PH_MACK_LOW : PH_RX_LOW;
      PH_RX_LOW:    phase_nxt = PH_RX_HIGH;
      PH_MACK_LOW:  phase_nxt = PH_MACK_HIGH;
      PH_MACK_HIGH: phase_nxt = PH_MACK_END;
      PH_MACK_END:  phase_nxt = (act_r == ACT_READ_NACK) ? PH_STOP_B : PH_IDLE;
      PH_STOP_B:    phase_nxt = PH_IDLE;
      PH_FAIL_STOP: phase_nxt = (is_addr && retries_r != '0) ? PH_START_SDA : PH_IDLE;
      default:      phase_nxt = PH_IDLE;
    endcase
  end

  always_comb begin
    bit_cnt_nxt   = bit_cnt_r;
    shift_nxt     = shift_r;
    retries_nxt   = retries_r;
    ack_wait_nxt  = ack_wait_r;
    act_nxt       = act_r;
    stop_pend_nxt = stop_pend_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    done          = 1'b0;
    status        = ST_OK;
    rd            = '0;
    case (phase_r)
      PH_IDLE: begin
        if (q_item.kind != KIND_NONE) begin
          act_nxt       = q_item.act;
          bit_cnt_nxt   = '0;
          ack_wait_nxt  = '0;
          stop_pend_nxt = 1'b0;
          case (q_item.kind)
            KIND_ADDR: begin
              shift_nxt   = q_item.load;
              retries_nxt = q_item.retries;
              scl_nxt     = 1'b1;
              sda_nxt     = 1'b1;
            end
            KIND_SEND: begin
              shift_nxt     = {q_item.load[6:0], q_item.load[7]};
              sda_nxt       = q_item.load[7];
              stop_pend_nxt = q_item.stop_flag;
            end
            KIND_READ: begin
              shift_nxt     = '0;
              stop_pend_nxt = q_item.stop_flag;
              scl_nxt       = 1'b0;
              sda_nxt       = 1'b1;
            end
            default: begin
              scl_nxt = 1'b0;
              sda_nxt = 1'b0;
            end
          endcase
        end
      end
      PH_START_SDA: sda_nxt = 1'b0;
      PH_START_SCL: begin
        scl_nxt     = 1'b0;
        bit_cnt_nxt = '0;
      end
      PH_TX_DRIVE: begin
        sda_nxt   = shift_r[7];
        shift_nxt = {shift_r[6:0], shift_r[7]};
      end
      PH_TX_HIGH: scl_nxt = 1'b1;
      PH_TX_LOW: begin
        scl_nxt     = 1'b0;
        bit_cnt_nxt = byte_end ? '0 : bit_inc;
      end
      PH_ACK_REL: sda_nxt = 1'b1;
      PH_ACK_HIGH: begin
        scl_nxt      = 1'b1;
        ack_wait_nxt = '0;
      end
      PH_ACK_POLL: begin
        if (!q_item.sda_in) begin
          scl_nxt = 1'b0;
          if (act_r == ACT_SEND && stop_pend_r) begin
            sda_nxt = 1'b0;
          end else begin
            done = 1'b1;
          end
        end else if (ack_expired) begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b0;
        end else begin
          ack_wait_nxt = ack_wait_r + 8'd1;
        end
      end
      PH_RX_HIGH: begin
        scl_nxt     = 1'b1;
        shift_nxt   = {shift_r[6:0], q_item.sda_in};
        bit_cnt_nxt = byte_end ? '0 : bit_inc;
      end
      PH_RX_LOW: scl_nxt = 1'b0;
      PH_MACK_LOW: begin
        scl_nxt = 1'b0;
        sda_nxt = (act_r == ACT_READ_NACK);
      end
      PH_MACK_HIGH: scl_nxt = 1'b1;
      PH_MACK_END: begin
        scl_nxt = 1'b0;
        if (act_r == ACT_READ_NACK) begin
          sda_nxt = 1'b0;
        end else begin
          done = 1'b1;
          rd   = shift_r;
        end
      end
      PH_STOP_B: begin
        scl_nxt = 1'b1;
        sda_nxt = 1'b1;
        done    = 1'b1;
        if (is_read) begin
          rd = shift_r;
        end
      end
      default: begin
        scl_nxt = 1'b1;
        sda_nxt = 1'b1;
        if (is_addr && retries_r != '0) begin
          retries_nxt = retries_r - 8'd1;
          bit_cnt_nxt = '0;
        end else begin
          done   = 1'b1;
          status = is_addr ? ST_ADDR_NACK : ST_DATA_NACK;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      bit_cnt_r     <= '0;
      shift_r       <= '0;
      retries_r     <= '0;
      ack_wait_r    <= '0;
      act_r         <= '0;
      stop_pend_r   <= 1'b0;
      scl_r         <= 1'b1;
      sda_r         <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      if (step) begin
        phase_r     <= phase_nxt;
        bit_cnt_r   <= bit_cnt_nxt;
        shift_r     <= shift_nxt;
        retries_r   <= retries_nxt;
        ack_wait_r  <= ack_wait_nxt;
        act_r       <= act_nxt;
        stop_pend_r <= stop_pend_nxt;
        scl_r       <= scl_nxt;
        sda_r       <= sda_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      ack_timeout_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_scl_r    <= scl_nxt;
      out_sda_r    <= sda_nxt;
      out_busy_r   <= (phase_nxt != PH_IDLE);
      out_done_r   <= done;
      out_status_r <= status;
      out_rd_r     <= rd;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_scl_level = out_scl_r;
  assign out_sda_level = out_sda_r;
  assign out_busy_res  = out_busy_r;
  assign out_done_res  = out_done_r;
  assign out_status    = out_status_r;
  assign out_read_data = out_rd_r;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> !out_busy_r)
    else $error("finished beat still reports busy");

  a_status_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_OK) |-> out_done_r)
    else $error("status reported without completion");

  a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r < 4'd8)
    else $error("bit counter out of range");

endmodule

/* rtl/i2c_master_bit_engine_unit.sv */
`timescale 1ns / 1ps
// I2C master bit engine, top level: one input beat is one 5 us bus tick and
// yields exactly one result beat with the driven SCL/SDA levels and status.
// Beats are taken one per clock cycle while the queue is not full. A beat is
// written into the queue when it is accepted; a later sequencer step pops it and
// loads the result register, a step that is held off while an earlier result
// waits on out_ready. The queue lets the input side keep going while a result
// waits, up to QUEUE_DEPTH beats. Write ack_timeout only while idle.
// Depends on i2cm_pkg, i2cm_front, i2cm_queue and i2cm_engine.
module i2c_master_bit_engine_unit
  import i2cm_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_sda_in,
  input  logic       in_cmd_valid,
  input  logic [2:0] in_action,
  input  logic [6:0] in_target_address,
  input  logic [7:0] in_data_byte,
  input  logic [7:0] in_retries,
  input  logic       in_stop_after,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_scl_level,
  output logic       out_sda_level,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [1:0] out_status,
  output logic [7:0] out_read_data
);

  logic    q_full;
  logic    q_push;
  q_item_t q_push_item;
  logic    q_pop;
  logic    q_head_valid;
  q_item_t q_head_item;

  i2cm_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sda_in         (in_sda_in),
    .in_cmd_valid      (in_cmd_valid),
    .in_action         (in_action),
    .in_target_address (in_target_address),
    .in_data_byte      (in_data_byte),
    .in_retries        (in_retries),
    .in_stop_after     (in_stop_after),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_item            (q_push_item)
  );

  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head_item)
  );

  i2cm_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .q_valid       (q_head_valid),
    .q_item        (q_head_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_scl_level (out_scl_level),
    .out_sda_level (out_sda_level),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_status    (out_status),
    .out_read_data (out_read_data)
  );

endmodule
